// ===== src/mecs_pkg.sv =====
// Shared types, constants and CRC helpers for the mnemonic encoder with CRC stream.
package mecs_pkg;

	localparam int MAX_WORDS = 1024;
	localparam int CAP_W = 11;
	localparam int POS_W = 10;
	localparam int CNT_W = 16;
	localparam int WORD_W = 32;
	localparam int IDX_W = 3;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [WORD_W-1:0] CRC_POLY = 32'h82F63B78;

	localparam logic [23:0] TXT_NOP = "NOP";
	localparam logic [23:0] TXT_RET = "RET";
	localparam logic [23:0] TXT_BRK = "BRK";
	localparam logic [23:0] TXT_HLT = "HLT";
	localparam logic [7:0] MATCH_LEN = 8'd3;

	typedef enum logic [1:0] {
		ARCH_A64   = 2'd0,
		ARCH_X86   = 2'd1,
		ARCH_RV    = 2'd2,
		ARCH_OTHER = 2'd3
	} arch_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ARCH = 3'd0,
		REG_CAP  = 3'd1,
		REG_NOP  = 3'd2,
		REG_RET  = 3'd3,
		REG_BRK  = 3'd4,
		REG_HLT  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MN_NOP = 2'd0,
		MN_RET = 2'd1,
		MN_BRK = 2'd2,
		MN_HLT = 2'd3
	} mnem_t;

	typedef logic [WORD_W-1:0] word_tab_t [4];

	localparam word_tab_t X86_WORDS = '{32'h00000090, 32'h000000C3, 32'h000000CC, 32'h000000F4};
	localparam word_tab_t RV_WORDS = '{32'h00000013, 32'h00008067, 32'h00100073, 32'h10500073};

	typedef struct packed {
		arch_t arch;
		logic [WORD_W-1:0] nop_word;
		logic [WORD_W-1:0] ret_word;
		logic [WORD_W-1:0] brk_word;
		logic [WORD_W-1:0] hlt_word;
	} enc_cfg_t;

	typedef struct packed {
		logic matched;
		logic [WORD_W-1:0] word;
		logic last;
	} job_t;

	typedef logic [WORD_W-1:0] crc_mat_t [WORD_W];

	// Column i is the fold of a word with only bit i set; the fold is linear over XOR.
	function automatic crc_mat_t crc_cols();
		crc_mat_t m;
		logic [WORD_W-1:0] x;
		for (int i = 0; i < WORD_W; i++) begin
			x = WORD_W'(1) << i;
			for (int k = 0; k < WORD_W; k++) begin
				x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
			end
			m[i] = x;
		end
		return m;
	endfunction

	localparam crc_mat_t CRC_COL = crc_cols();

	function automatic logic [WORD_W-1:0] crc_fold(input logic [WORD_W-1:0] crc,
		input logic [WORD_W-1:0] word);
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] r;
		x = crc ^ word;
		r = '0;
		for (int i = 0; i < WORD_W; i++) begin
			r = r ^ (x[i] ? CRC_COL[i] : '0);
		end
		return r;
	endfunction

endpackage

// ===== src/mecs_token_if.sv =====
// Token channel: valid, ready and one mnemonic token.
interface mecs_token_if;
	logic valid;
	logic ready;
	logic [7:0] token_length;
	logic [7:0] char_first;
	logic [7:0] char_second;
	logic [7:0] char_third;
	logic last_of_block;

	modport source(output valid, token_length, char_first, char_second, char_third,
		last_of_block, input ready);
	modport sink(input valid, token_length, char_first, char_second, char_third,
		last_of_block, output ready);
endinterface

// ===== src/mecs_result_if.sv =====
// Result channel: valid, ready and one encoder result word.
interface mecs_result_if;
	logic valid;
	logic ready;
	logic word_valid;
	logic [31:0] instr_word;
	logic [9:0] word_position;
	logic [15:0] accepted_total;
	logic [15:0] rejected_total;
	logic [31:0] crc_value;
	logic block_end;

	modport source(output valid, word_valid, instr_word, word_position, accepted_total,
		rejected_total, crc_value, block_end, input ready);
	modport sink(input valid, word_valid, instr_word, word_position, accepted_total,
		rejected_total, crc_value, block_end, output ready);
endinterface

// ===== src/mnemonic_encode_crc_stream_unit.sv =====
// Top level of the mnemonic encoder with running CRC-32C over the emitted words.
// A token is written into the queue and then popped into the registered result stage; a held result can stall it.
// Throughput: one token per cycle while the queue is not full; the front end and back end each take one word a cycle
// when not stalled, with a two-entry queue between them and a registered result stage.
// Reset: arst_n clears the queue, counters, position and CRC and loads the register defaults.
module mnemonic_encode_crc_stream_unit (
	input logic clk,
	input logic arst_n,
	mecs_token_if.sink tok,
	mecs_result_if.source res,
	input logic cfg_we,
	input logic [mecs_pkg::IDX_W-1:0] cfg_index,
	input logic [mecs_pkg::WORD_W-1:0] cfg_data
);
	import mecs_pkg::*;

	enc_cfg_t cfg_q;
	logic [CAP_W-1:0] capacity_q;

	logic push;
	job_t push_job;
	logic q_full;
	logic q_pop;
	logic q_valid;
	job_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arch <= ARCH_A64;
			capacity_q <= CAP_W'(MAX_WORDS);
			cfg_q.nop_word <= 32'hD503201F;
			cfg_q.ret_word <= 32'hD65F03C0;
			cfg_q.brk_word <= 32'hD4200000;
			cfg_q.hlt_word <= 32'hD4400000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ARCH: cfg_q.arch <= arch_t'(cfg_data[1:0]);
				REG_CAP: capacity_q <= cfg_data[CAP_W-1:0];
				REG_NOP: cfg_q.nop_word <= cfg_data;
				REG_RET: cfg_q.ret_word <= cfg_data;
				REG_BRK: cfg_q.brk_word <= cfg_data;
				REG_HLT: cfg_q.hlt_word <= cfg_data;
				default: ;
			endcase
		end
	end

	mecs_front u_front (
		.tok(tok),
		.cfg(cfg_q),
		.q_full(q_full),
		.push(push),
		.job(push_job)
	);

	mecs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_job),
		.full(q_full),
		.pop(q_pop),
		.q_valid(q_valid),
		.q_data(q_data)
	);

	mecs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.capacity(capacity_q),
		.q_valid(q_valid),
		.q_data(q_data),
		.pop(q_pop),
		.res(res)
	);

endmodule

// ===== src/mecs_front.sv =====
// Front end: takes tokens, matches the mnemonic and picks the instruction word.
module mecs_front (
	mecs_token_if.sink tok,
	input mecs_pkg::enc_cfg_t cfg,
	input logic q_full,
	output logic push,
	output mecs_pkg::job_t job
);
	import mecs_pkg::*;

	logic [23:0] text;
	logic hit;
	mnem_t which;

	assign tok.ready = !q_full;
	assign push = tok.valid && !q_full;
	assign text = {tok.char_first, tok.char_second, tok.char_third};

	always_comb begin
		hit = 1'b0;
		which = MN_NOP;
		if (tok.token_length == MATCH_LEN) begin
			if (text == TXT_NOP) begin
				hit = 1'b1;
				which = MN_NOP;
			end else if (text == TXT_RET) begin
				hit = 1'b1;
				which = MN_RET;
			end else if (text == TXT_BRK) begin
				hit = 1'b1;
				which = MN_BRK;
			end else if (text == TXT_HLT) begin
				hit = 1'b1;
				which = MN_HLT;
			end
		end
	end

	always_comb begin
		job.matched = hit;
		job.last = tok.last_of_block;
		case (cfg.arch)
			ARCH_X86: job.word = X86_WORDS[which];
			ARCH_RV: job.word = RV_WORDS[which];
			default: begin
				case (which)
					MN_NOP: job.word = cfg.nop_word;
					MN_RET: job.word = cfg.ret_word;
					MN_BRK: job.word = cfg.brk_word;
					default: job.word = cfg.hlt_word;
				endcase
			end
		endcase
	end

endmodule

// ===== src/mecs_queue.sv =====
// Two-entry queue between the front end and the back end.
module mecs_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mecs_pkg::job_t push_data,
	output logic full,
	input logic pop,
	output logic q_valid,
	output mecs_pkg::job_t q_data
);
	import mecs_pkg::*;

	job_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) full |-> !push;
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue written while full");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n) pop |-> q_valid;
	endproperty
	a_no_underflow: assert property (p_no_underflow) else $error("queue read while empty");

	property p_count_step;
		@(posedge clk) disable iff (!arst_n) (push && !pop) |=> count_q == $past(count_q) + 2'd1;
	endproperty
	a_count_step: assert property (p_count_step) else $error("queue count did not advance");

endmodule

// ===== src/mecs_back.sv =====
// Back end: buffer position, counters, running CRC-32C and the output register.
module mecs_back (
	input logic clk,
	input logic arst_n,
	input logic [mecs_pkg::CAP_W-1:0] capacity,
	input logic q_valid,
	input mecs_pkg::job_t q_data,
	output logic pop,
	mecs_result_if.source res
);
	import mecs_pkg::*;

	logic [CAP_W-1:0] wp_q;
	logic [CNT_W-1:0] acc_q;
	logic [CNT_W-1:0] rej_q;
	logic [WORD_W-1:0] crc_q;

	logic out_valid_q;
	logic word_valid_q;
	logic [WORD_W-1:0] instr_word_q;
	logic [POS_W-1:0] word_position_q;
	logic [CNT_W-1:0] acc_out_q;
	logic [CNT_W-1:0] rej_out_q;
	logic [WORD_W-1:0] crc_out_q;
	logic block_end_q;

	logic [CAP_W-1:0] cap_eff;
	logic active;
	logic take;
	logic [CAP_W-1:0] wp_n;
	logic [CNT_W-1:0] acc_n;
	logic [CNT_W-1:0] rej_n;
	logic [WORD_W-1:0] crc_n;

	assign pop = q_valid && (!out_valid_q || res.ready);

	assign cap_eff = (capacity > CAP_W'(MAX_WORDS)) ? CAP_W'(MAX_WORDS) : capacity;
	assign active = (cap_eff != '0);
	assign take = active && q_data.matched && (wp_q < cap_eff);

	always_comb begin
		wp_n = take ? (wp_q + CAP_W'(1)) : wp_q;
		acc_n = (take && acc_q != COUNT_MAX) ? (acc_q + CNT_W'(1)) : acc_q;
		rej_n = (active && !take && rej_q != COUNT_MAX) ? (rej_q + CNT_W'(1)) : rej_q;
		crc_n = take ? crc_fold(crc_q, q_data.word) : crc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			acc_q <= '0;
			rej_q <= '0;
			crc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (q_data.last) begin
					wp_q <= '0;
					acc_q <= '0;
					rej_q <= '0;
					crc_q <= '0;
				end else begin
					wp_q <= wp_n;
					acc_q <= acc_n;
					rej_q <= rej_n;
					crc_q <= crc_n;
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_valid_q <= take;
			instr_word_q <= take ? q_data.word : '0;
			word_position_q <= take ? wp_q[POS_W-1:0] : '0;
			acc_out_q <= acc_n;
			rej_out_q <= rej_n;
			crc_out_q <= crc_n;
			block_end_q <= q_data.last;
		end
	end

	assign res.valid = out_valid_q;
	assign res.word_valid = word_valid_q;
	assign res.instr_word = instr_word_q;
	assign res.word_position = word_position_q;
	assign res.accepted_total = acc_out_q;
	assign res.rejected_total = rej_out_q;
	assign res.crc_value = crc_out_q;
	assign res.block_end = block_end_q;

	property p_empty_word;
		@(posedge clk) disable iff (!arst_n)
			(res.valid && !res.word_valid) |-> (res.instr_word == '0 && res.word_position == '0);
	endproperty
	a_empty_word: assert property (p_empty_word) else $error("rejected word carries data");

	property p_position_bound;
		@(posedge clk) disable iff (!arst_n) wp_q <= CAP_W'(MAX_WORDS);
	endproperty
	a_position_bound: assert property (p_position_bound) else $error("write position too large");

	property p_block_clear;
		@(posedge clk) disable iff (!arst_n)
			(pop && q_data.last) |=> (wp_q == '0 && acc_q == '0 && rej_q == '0 && crc_q == '0);
	endproperty
	a_block_clear: assert property (p_block_clear) else $error("state not cleared after block");

	property p_hold_result;
		@(posedge clk) disable iff (!arst_n) (res.valid && !res.ready) |-> !pop;
	endproperty
	a_hold_result: assert property (p_hold_result) else $error("result overwritten while stalled");

endmodule
